FILE: rtl/lipe_pkg.sv
// Package for the LED indicator pattern engine: payload types, codes and
// pattern timing constants. No dependencies.
`timescale 1ns / 1ps

package lipe_pkg;

    // item actions
    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_NOTIFY = 3'd1;
    localparam logic [2:0] ACT_BLINK  = 3'd2;
    localparam logic [2:0] ACT_SET    = 3'd3;
    localparam logic [2:0] ACT_BUSY   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_BRIGHTNESS = 2'd0;
    localparam logic [1:0] CFG_INVERT     = 2'd1;
    localparam logic [1:0] CFG_EXT_SCAN   = 2'd2;

    // pattern modes
    typedef enum logic [2:0] {
        MODE_OFF    = 3'd0,
        MODE_ON     = 3'd1,
        MODE_SLOW   = 3'd2,
        MODE_FAST   = 3'd3,
        MODE_NBLINK = 3'd4,
        MODE_SEARCH = 3'd5,
        MODE_BUSY   = 3'd6
    } mode_t;

    // mode code with no mode behind it
    localparam logic [2:0] MODE_CODE_UNUSED = 3'd7;

    // proximity levels
    localparam logic [2:0] PROX_TOUCH = 3'd4;
    localparam logic [2:0] PROX_NEAR  = 3'd3;
    localparam logic [2:0] PROX_MID   = 3'd2;
    localparam logic [2:0] PROX_FAR   = 3'd1;

    // half periods in ms
    localparam int unsigned PER_NEAR   = 150;
    localparam int unsigned PER_MID    = 400;
    localparam int unsigned PER_FAR    = 800;   // also the slow pattern
    localparam int unsigned PER_FAST   = 250;
    localparam int unsigned PER_SEARCH = 1000;
    localparam int unsigned BLINK_STEP = 200;

    // busy double blink
    localparam int unsigned BUSY_CYCLE    = 300;
    localparam int unsigned BUSY_ON1_END  = 100;
    localparam int unsigned BUSY_ON2_BEG  = 150;
    localparam int unsigned BUSY_ON2_END  = 250;
    localparam int unsigned BUSY_RESTART  = 1000;
    localparam int unsigned BUSY_TIMEOUT  = 5000;

    localparam int unsigned QFILL_W = 4;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  count;
        logic [15:0] on_time;
        logic [15:0] off_time;
        logic [2:0]  mode_code;
        logic        busy_flag;
        logic        ambient_active;
        logic [2:0]  ambient_level;
        logic        suspended;
    } item_t;

    typedef struct packed {
        logic [7:0]         led_level;
        logic               led_lit;
        logic               scan_led_on;
        logic [2:0]         current_mode;
        logic [QFILL_W-1:0] queue_fill;
        logic               request_dropped;
    } result_t;

    typedef struct packed {
        logic [1:0] index;
        logic [7:0] data;
    } cfg_t;

    typedef struct packed {
        logic [7:0] brightness;
        logic       invert_output;
        logic       external_scan_led;
    } cfg_regs_t;

    typedef struct packed {
        logic [7:0]  count;
        logic [15:0] on_time;
        logic [15:0] off_time;
    } notify_entry_t;

    typedef struct packed {
        logic          push;
        logic          pop;
        notify_entry_t data;
    } fifo_req_t;

    typedef struct packed {
        logic          full;
        logic          empty;
        notify_entry_t head;
    } fifo_stat_t;

endpackage

FILE: rtl/lipe_stream_if.sv
// Valid/ready channel carrying one payload of a given type.
// Used for input items, results and configuration writes.
`timescale 1ns / 1ps

interface lipe_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/lipe_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module lipe_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 8
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/lipe_notify_fifo.sv
// Notify request queue: RAM storage with a prefetched head entry.
// Depends on lipe_pkg and lipe_ram.
`timescale 1ns / 1ps

module lipe_notify_fifo #(
    parameter int DEPTH = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lipe_pkg::fifo_req_t                 req,
    output lipe_pkg::fifo_stat_t                stat,
    output logic [lipe_pkg::QFILL_W-1:0]        fill_level
);

    import lipe_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam int EW = $bits(notify_entry_t);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          byp_valid_reg;
    logic [EW-1:0] byp_data_reg;
    logic [EW-1:0] ram_rdata;
    logic          hit;
    notify_entry_t stored_head;

    // pointer and count update
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (req.push)
        begin
            tail_next = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (req.pop)
        begin
            head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        fill_next = fill_reg + FW'(req.push) - FW'(req.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            byp_valid_reg <= hit;
        end
    end

    // a write to the entry being fetched bypasses the RAM
    assign hit = req.push && (tail_reg == head_next);

    always_ff @(posedge clk)
    begin
        byp_data_reg <= req.data;
    end

    lipe_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (req.push),
        .waddr (tail_reg),
        .wdata (req.data),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    // head: the pushed request when the queue is empty
    always_comb
    begin
        stored_head = byp_valid_reg ? notify_entry_t'(byp_data_reg)
                                    : notify_entry_t'(ram_rdata);
        stat.full  = (fill_reg == FW'(DEPTH));
        stat.empty = (fill_reg == '0);
        stat.head  = stat.empty ? req.data : stored_head;
    end

    assign fill_level = QFILL_W'(fill_next);

endmodule

FILE: rtl/lipe_core.sv
// Command handling, timing counters and pattern select for one item.
// Depends on lipe_pkg.
`timescale 1ns / 1ps

module lipe_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  lipe_pkg::item_t               item,
    input  lipe_pkg::cfg_regs_t           cfg_regs,
    input  lipe_pkg::fifo_stat_t          fifo_stat,
    input  logic [lipe_pkg::QFILL_W-1:0]  qfill,
    output lipe_pkg::fifo_req_t           fifo_req,
    output lipe_pkg::result_t             res
);

    import lipe_pkg::*;

    localparam int NEAR_W   = $clog2(2 * PER_NEAR);
    localparam int MID_W    = $clog2(2 * PER_MID);
    localparam int FAR_W    = $clog2(2 * PER_FAR);
    localparam int FAST_W   = $clog2(2 * PER_FAST);
    localparam int SEARCH_W = $clog2(2 * PER_SEARCH);
    localparam int E300_W   = $clog2(BUSY_CYCLE);
    localparam int E400_W   = $clog2(2 * BLINK_STEP);

    // state
    logic [31:0]         time_reg, time_next;
    mode_t               mode_reg, mode_next;
    mode_t               after_reg, after_next;
    logic [15:0]         limit_reg, limit_next;
    logic [31:0]         elapsed_reg, elapsed_next;
    logic [E300_W-1:0]   e300_reg, e300_next;
    logic [E400_W-1:0]   e400_reg, e400_next;
    logic [31:0]         deadline_reg, deadline_next;
    logic [7:0]          left_reg, left_next;
    logic [15:0]         on_reg, on_next;
    logic [15:0]         off_reg, off_next;
    logic [16:0]         phase_reg, phase_next;
    logic [NEAR_W-1:0]   near_reg, near_next;
    logic [MID_W-1:0]    mid_reg, mid_next;
    logic [FAR_W-1:0]    far_reg, far_next;
    logic [FAST_W-1:0]   fast_reg, fast_next;
    logic [SEARCH_W-1:0] search_reg, search_next;

    logic        t_wrap, e_wrap;
    logic [16:0] phase_inc;
    logic [2:0]  level;
    logic        prox, lit, dropped, push, pop, busy_shown;
    logic [8:0]  busy_r;
    mode_t       mode_cmd;

    // command, tick and pattern evaluation
    always_comb
    begin
        time_next     = time_reg;
        mode_next     = mode_reg;
        after_next    = after_reg;
        limit_next    = limit_reg;
        elapsed_next  = elapsed_reg;
        e300_next     = e300_reg;
        e400_next     = e400_reg;
        deadline_next = deadline_reg;
        left_next     = left_reg;
        on_next       = on_reg;
        off_next      = off_reg;
        phase_next    = phase_reg;
        near_next     = near_reg;
        mid_next      = mid_reg;
        far_next      = far_reg;
        fast_next     = fast_reg;
        search_next   = search_reg;
        t_wrap        = &time_reg;
        e_wrap        = &elapsed_reg;
        phase_inc     = phase_reg + 1'b1;
        dropped       = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        lit           = 1'b0;
        busy_shown    = 1'b0;
        busy_r        = 9'(e300_reg);
        mode_cmd      = mode_t'(item.mode_code);

        case (item.action)
            ACT_TICK:
            begin
                time_next = time_reg + 1'b1;
                // phase counters restart with the time counter wrap
                near_next = (t_wrap || near_reg == NEAR_W'(2 * PER_NEAR - 1))
                          ? '0 : near_reg + 1'b1;
                mid_next = (t_wrap || mid_reg == MID_W'(2 * PER_MID - 1))
                         ? '0 : mid_reg + 1'b1;
                far_next = (t_wrap || far_reg == FAR_W'(2 * PER_FAR - 1))
                         ? '0 : far_reg + 1'b1;
                fast_next = (t_wrap || fast_reg == FAST_W'(2 * PER_FAST - 1))
                          ? '0 : fast_reg + 1'b1;
                search_next = (t_wrap || search_reg == SEARCH_W'(2 * PER_SEARCH - 1))
                            ? '0 : search_reg + 1'b1;
                // time since blink origin
                elapsed_next = elapsed_reg + 1'b1;
                e300_next = (e_wrap || e300_reg == E300_W'(BUSY_CYCLE - 1))
                          ? '0 : e300_reg + 1'b1;
                e400_next = (e_wrap || e400_reg == E400_W'(2 * BLINK_STEP - 1))
                          ? '0 : e400_reg + 1'b1;
                // burst phase
                if (left_reg != '0)
                begin
                    if (phase_inc >= (17'(on_reg) + 17'(off_reg)))
                    begin
                        phase_next = '0;
                        left_next  = left_reg - 1'b1;
                    end
                    else
                    begin
                        phase_next = phase_inc;
                    end
                end
            end
            ACT_NOTIFY:
            begin
                if (item.count == '0 || fifo_stat.full)
                begin
                    dropped = 1'b1;
                end
                else
                begin
                    push = 1'b1;
                end
            end
            ACT_BLINK:
            begin
                mode_next  = MODE_NBLINK;
                after_next = (item.mode_code == MODE_CODE_UNUSED) ? MODE_OFF : mode_cmd;
                limit_next = 16'(16'(item.count) * 16'(BLINK_STEP));
                elapsed_next = '0;
                e300_next    = '0;
                e400_next    = '0;
            end
            ACT_SET:
            begin
                if (item.mode_code inside {MODE_OFF, MODE_ON, MODE_SLOW, MODE_FAST,
                                           MODE_SEARCH})
                begin
                    mode_next = mode_cmd;
                end
            end
            ACT_BUSY:
            begin
                if (item.busy_flag)
                begin
                    mode_next     = MODE_BUSY;
                    deadline_next = time_reg + 32'(BUSY_TIMEOUT);
                end
                else
                begin
                    if (mode_reg == MODE_BUSY)
                    begin
                        mode_next = MODE_ON;
                    end
                    deadline_next = '0;
                end
            end
            default:
            begin
            end
        endcase

        // proximity indication on the updated time
        level = item.ambient_active ? item.ambient_level : 3'd0;
        case (level)
            PROX_TOUCH: prox = 1'b1;
            PROX_NEAR:  prox = (near_next < NEAR_W'(PER_NEAR));
            PROX_MID:   prox = (mid_next < MID_W'(PER_MID));
            PROX_FAR:   prox = (far_next < FAR_W'(PER_FAR));
            default:    prox = 1'b0;
        endcase
        prox = prox && item.ambient_active;

        // take the queue head when no burst plays
        if (left_next == '0 && (!fifo_stat.empty || push))
        begin
            pop        = 1'b1;
            left_next  = fifo_stat.head.count;
            on_next    = fifo_stat.head.on_time;
            off_next   = fifo_stat.head.off_time;
            phase_next = '0;
        end

        // pattern select by priority
        if (left_next != '0)
        begin
            lit = (phase_next < 17'(on_next));
        end
        else if (item.ambient_active && !cfg_regs.external_scan_led && item.suspended)
        begin
            lit = prox;
        end
        else if (mode_next == MODE_SEARCH)
        begin
            lit = item.ambient_active ? prox : (search_next < SEARCH_W'(PER_SEARCH));
        end
        else if (!item.suspended)
        begin
            if (mode_next == MODE_BUSY)
            begin
                if (deadline_next != '0 && time_next >= deadline_next)
                begin
                    mode_next = MODE_ON;
                end
                else
                begin
                    busy_shown = 1'b1;
                    busy_r     = 9'(e300_next);
                    lit = (busy_r < 9'(BUSY_ON1_END))
                       || (busy_r > 9'(BUSY_ON2_BEG) && busy_r < 9'(BUSY_ON2_END));
                    if (elapsed_next >= 32'(BUSY_RESTART))
                    begin
                        elapsed_next = '0;
                        e300_next    = '0;
                        e400_next    = '0;
                    end
                end
            end
            if (!busy_shown)
            begin
                if (mode_next == MODE_NBLINK)
                begin
                    if (elapsed_next >= 32'(limit_next))
                    begin
                        mode_next = after_next;
                    end
                    else
                    begin
                        lit = (e400_next < E400_W'(BLINK_STEP));
                    end
                end
                case (mode_next)
                    MODE_ON:   lit = 1'b1;
                    MODE_OFF:  lit = 1'b0;
                    MODE_SLOW: lit = (far_next < FAR_W'(PER_FAR));
                    MODE_FAST: lit = (fast_next < FAST_W'(PER_FAST));
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // queue requests, zero on-time stored as one ms
    always_comb
    begin
        fifo_req.push          = push && fire;
        fifo_req.pop           = pop && fire;
        fifo_req.data.count    = item.count;
        fifo_req.data.on_time  = (item.on_time == '0) ? 16'd1 : item.on_time;
        fifo_req.data.off_time = item.off_time;
    end

    // result fields
    always_comb
    begin
        if (cfg_regs.invert_output)
        begin
            res.led_level = lit ? 8'd0 : cfg_regs.brightness;
        end
        else
        begin
            res.led_level = lit ? cfg_regs.brightness : 8'd0;
        end
        res.led_lit         = lit;
        res.scan_led_on     = cfg_regs.external_scan_led && prox;
        res.current_mode    = mode_next;
        res.queue_fill      = qfill;
        res.request_dropped = dropped;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg     <= '0;
            mode_reg     <= MODE_ON;
            after_reg    <= MODE_ON;
            limit_reg    <= '0;
            elapsed_reg  <= '0;
            e300_reg     <= '0;
            e400_reg     <= '0;
            deadline_reg <= '0;
            left_reg     <= '0;
            on_reg       <= '0;
            off_reg      <= '0;
            phase_reg    <= '0;
            near_reg     <= '0;
            mid_reg      <= '0;
            far_reg      <= '0;
            fast_reg     <= '0;
            search_reg   <= '0;
        end
        else if (fire)
        begin
            time_reg     <= time_next;
            mode_reg     <= mode_next;
            after_reg    <= after_next;
            limit_reg    <= limit_next;
            elapsed_reg  <= elapsed_next;
            e300_reg     <= e300_next;
            e400_reg     <= e400_next;
            deadline_reg <= deadline_next;
            left_reg     <= left_next;
            on_reg       <= on_next;
            off_reg      <= off_next;
            phase_reg    <= phase_next;
            near_reg     <= near_next;
            mid_reg      <= mid_next;
            far_reg      <= far_next;
            fast_reg     <= fast_next;
            search_reg   <= search_next;
        end
    end

endmodule

FILE: rtl/led_indicator_pattern_engine.sv
// LED indicator pattern engine: usage notes.
// Channels: "item" takes one request per handshake (a 1 ms tick or a command
// with the present proximity and suspend status); "result" returns exactly one
// result per request, in order; "cfg" writes brightness (index 0), output
// inversion (1) and external scan LED presence (2), always ready.
// Flow: a request is taken into the input register, passes the pattern logic
// and its result is held in the result register. Throughput: one request per
// cycle while results are taken; the input register, the single pass of pattern
// logic and the result register form a two-stage pipeline. The notify queue
// holds NOTIFY_DEPTH requests in a RAM whose head entry is prefetched.
// Reset: time 0, solid on mode, empty queue, brightness 255, no inversion,
// no external LED. The queue RAM needs no clearing.
// Stall: while result is not taken, one more request is held in the input
// register; after that, item.ready drops until the result is consumed.
// Configuration must be written only while no request is in flight.
// Depends on lipe_pkg, lipe_stream_if, lipe_core, lipe_notify_fifo, lipe_ram.
`timescale 1ns / 1ps

module led_indicator_pattern_engine #(
    parameter int NOTIFY_DEPTH = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    lipe_stream_if.sink   item,
    lipe_stream_if.source result,
    lipe_stream_if.sink   cfg
);

    import lipe_pkg::*;

    logic       in_valid_reg, in_valid_next;
    item_t      in_item_reg;
    logic       res_valid_reg, res_valid_next;
    result_t    res_reg;
    cfg_regs_t  cfg_reg, cfg_next;
    logic       advance, fire, accept;
    result_t    core_res;
    fifo_req_t  fifo_req;
    fifo_stat_t fifo_stat;
    logic [QFILL_W-1:0] qfill;

    // pipeline handshake
    assign advance    = !res_valid_reg || result.ready;
    assign fire       = in_valid_reg && advance;
    assign item.ready = !in_valid_reg || advance;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        res_valid_next = res_valid_reg;
        if (fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= item.payload;
        end
        if (fire)
        begin
            res_reg <= core_res;
        end
    end

    assign result.valid   = res_valid_reg;
    assign result.payload = res_reg;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.payload.index)
                CFG_BRIGHTNESS: cfg_next.brightness        = cfg.payload.data;
                CFG_INVERT:     cfg_next.invert_output     = cfg.payload.data[0];
                CFG_EXT_SCAN:   cfg_next.external_scan_led = cfg.payload.data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.brightness        <= 8'hFF;
            cfg_reg.invert_output     <= 1'b0;
            cfg_reg.external_scan_led <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lipe_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (in_item_reg),
        .cfg_regs  (cfg_reg),
        .fifo_stat (fifo_stat),
        .qfill     (qfill),
        .fifo_req  (fifo_req),
        .res       (core_res)
    );

    lipe_notify_fifo #(
        .DEPTH (NOTIFY_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (fifo_req),
        .stat       (fifo_stat),
        .fill_level (qfill)
    );

endmodule
